FILE: hdl/rrle_pkg.sv
// ---------------------------------------------------------------------------
// rrle_pkg
// Shared types and constants for the row-clipped RLE pixel decoder.
// ---------------------------------------------------------------------------
package rrle_pkg;

    localparam int unsigned MAX_WIDTH = 1024;
    localparam int unsigned MAX_ROWS  = 1024;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [15:0] KEY_PIXEL = 16'hF81F;
    localparam logic [7:0]  RUN_FLAG  = 8'h80;
    localparam logic [6:0]  COUNT_MSK = 7'h7F;

    localparam logic [10:0] RST_ROW_WIDTH = 11'd64;
    localparam logic [10:0] RST_ROW_TOTAL = 11'd64;
    localparam logic [20:0] RST_CAPACITY  = 21'h100000;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH  = 2'd0,
        REG_ROW_TOTAL  = 2'd1,
        REG_PIXEL_MODE = 2'd2,
        REG_CAPACITY   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_CTRL   = 3'd0,
        PH_RUN_LO = 3'd1,
        PH_RUN_HI = 3'd2,
        PH_LIT_LO = 3'd3,
        PH_LIT_HI = 3'd4
    } t_phase;

    typedef struct packed {
        logic [10:0] row_width;
        logic [10:0] row_total;
        logic        pixel_mode;
        logic [20:0] capacity;
    } t_cfg;

    // One queue entry: the decoded run of a byte and/or the padding request.
    typedef struct packed {
        logic        run_v;
        logic [15:0] run_pix;
        logic [6:0]  run_n;
        logic        pad_v;
        logic        pad_none;
        logic        wide;
        logic        alpha;
        logic [10:0] rows_left;
        logic [10:0] w;
        logic [10:0] col;
        logic [20:0] pw;
        logic [20:0] cap;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // One result piece as it enters the back pipeline.
    typedef struct packed {
        logic        is_pad;
        logic [15:0] pix;
        logic [6:0]  run_n;
        logic        pad_none;
        logic        wide;
        logic        alpha;
        logic [10:0] rows_left;
        logic [10:0] w;
        logic [10:0] col;
        logic [20:0] pw;
        logic [20:0] cap;
    } t_piece;

    // Piece after the area product and the capacity headroom are known.
    typedef struct packed {
        logic        is_pad;
        logic [15:0] pix;
        logic [6:0]  run_n;
        logic        pad_none;
        logic        wide;
        logic        alpha;
        logic [20:0] prod;
        logic [20:0] capleft;
        logic [10:0] col;
        logic [20:0] pw;
    } t_padcalc;

endpackage

FILE: hdl/row_rle_pixel_decoder_core.sv
// ---------------------------------------------------------------------------
// row_rle_pixel_decoder_core
// Row-clipped run-length sprite decoder with APB configuration.
// ---------------------------------------------------------------------------
// Usage:
//   Source bytes enter on i_src_valid / o_src_stall, one byte per item, with
//   i_src_final on the last byte of a sprite. Results leave on o_res_valid /
//   i_res_stall as runs: pixel value and repeat count, plus the padding run
//   that closes each sprite (o_final_item, with o_alpha_seen and
//   o_bytes_written).
//   One byte is taken every cycle while the queue is not full. A byte
//   yields at most one decoded run, the final byte also the padding run; a
//   byte with both goes out as two results, the only place besides
//   i_res_stall where the result side runs slower than one per cycle. A
//   result reaches the output via the queue write, then area multiply
//   stage, clip stage, output register.
//   A four-entry queue sits between byte decode and result generation; when
//   it fills, o_src_stall rises. While a result waits under i_res_stall it
//   holds and the result pipeline freezes.
//   Reset clears the token state, the queue and the pipeline and loads the
//   register defaults (64 x 64, 8-bit pixels, full capacity). Registers are
//   written over APB at byte addresses 0, 4, 8, 12.
// ---------------------------------------------------------------------------
module row_rle_pixel_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_src_valid,
    output logic        o_src_stall,
    input  logic [7:0]  i_src_byte,
    input  logic        i_src_final,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [15:0] o_pixel_value,
    output logic [20:0] o_repeat_count,
    output logic        o_is_padding,
    output logic        o_alpha_seen,
    output logic        o_final_item,
    output logic [21:0] o_bytes_written
);

    rrle_pkg::t_cfg      r_cfg;
    rrle_pkg::t_reg_idx  reg_idx;
    logic                cfg_wr;
    logic                push;
    logic                pop;
    rrle_pkg::t_entry    push_entry;
    rrle_pkg::t_entry    head_entry;
    rrle_pkg::t_q_status q_status;

    assign pready  = 1'b1;
    assign reg_idx = rrle_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width  <= rrle_pkg::RST_ROW_WIDTH;
            r_cfg.row_total  <= rrle_pkg::RST_ROW_TOTAL;
            r_cfg.pixel_mode <= 1'b0;
            r_cfg.capacity   <= rrle_pkg::RST_CAPACITY;
        end else if (cfg_wr) begin
            case (reg_idx)
                rrle_pkg::REG_ROW_WIDTH:  r_cfg.row_width  <= pwdata[10:0];
                rrle_pkg::REG_ROW_TOTAL:  r_cfg.row_total  <= pwdata[10:0];
                rrle_pkg::REG_PIXEL_MODE: r_cfg.pixel_mode <= pwdata[0];
                rrle_pkg::REG_CAPACITY:   r_cfg.capacity   <= pwdata[20:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rrle_pkg::REG_ROW_WIDTH:  prdata = {21'd0, r_cfg.row_width};
            rrle_pkg::REG_ROW_TOTAL:  prdata = {21'd0, r_cfg.row_total};
            rrle_pkg::REG_PIXEL_MODE: prdata = {31'd0, r_cfg.pixel_mode};
            rrle_pkg::REG_CAPACITY:   prdata = {11'd0, r_cfg.capacity};
            default:                  prdata = 32'd0;
        endcase
    end

    rrle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_src_valid (i_src_valid),
        .i_src_byte  (i_src_byte),
        .i_src_final (i_src_final),
        .i_q_status  (q_status),
        .o_src_stall (o_src_stall),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    rrle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    rrle_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (head_entry),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_pixel_value   (o_pixel_value),
        .o_repeat_count  (o_repeat_count),
        .o_is_padding    (o_is_padding),
        .o_alpha_seen    (o_alpha_seen),
        .o_final_item    (o_final_item),
        .o_bytes_written (o_bytes_written)
    );

endmodule

FILE: hdl/rrle_front.sv
// ---------------------------------------------------------------------------
// rrle_front
// Accepts source bytes, runs the token state machine with row and capacity
// clipping, and pushes one queue entry per byte that produces a result.
// ---------------------------------------------------------------------------
module rrle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrle_pkg::t_cfg      i_cfg,
    input  logic                i_src_valid,
    input  logic [7:0]          i_src_byte,
    input  logic                i_src_final,
    input  rrle_pkg::t_q_status i_q_status,
    output logic                o_src_stall,
    output logic                o_push,
    output rrle_pkg::t_entry    o_entry
);

    rrle_pkg::t_phase r_phase, n_phase;
    logic [6:0]  r_left, n_left;
    logic [7:0]  r_low, n_low;
    logic [10:0] r_col, n_col;
    logic [10:0] r_row, n_row;
    logic [20:0] r_pw, n_pw;
    logic        r_alpha, n_alpha;

    logic        accept;
    logic        wide;
    logic [10:0] w, rows;
    logic        done, done_after;
    logic [10:0] room;
    logic [20:0] capleft;
    logic        full;
    logic [15:0] pix;
    logic        have;
    logic        run;
    logic [6:0]  m;
    logic [11:0] col_sum;
    logic        row_end;
    logic        full_after;

    assign accept      = i_src_valid && !i_q_status.full;
    assign o_src_stall = i_q_status.full;
    assign wide        = i_cfg.pixel_mode;

    assign w    = (i_cfg.row_width > 11'(rrle_pkg::MAX_WIDTH)) ?
                  11'(rrle_pkg::MAX_WIDTH) : i_cfg.row_width;
    assign rows = (i_cfg.row_total > 11'(rrle_pkg::MAX_ROWS)) ?
                  11'(rrle_pkg::MAX_ROWS) : i_cfg.row_total;

    assign done    = (w == 11'd0) || (r_row >= rows);
    assign room    = (r_col < w) ? (w - r_col) : 11'd0;
    assign capleft = (r_pw < i_cfg.capacity) ? (i_cfg.capacity - r_pw) : 21'd0;
    assign full    = (r_pw >= i_cfg.capacity);

    // Token decode and placement.
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_low      = r_low;
        n_col      = r_col;
        n_row      = r_row;
        n_pw       = r_pw;
        n_alpha    = r_alpha;
        pix        = 16'd0;
        have       = 1'b0;
        run        = (r_phase == rrle_pkg::PH_RUN_LO) || (r_phase == rrle_pkg::PH_RUN_HI);
        m          = 7'd0;
        col_sum    = 12'd0;
        row_end    = 1'b0;
        full_after = full;

        if (!done) begin
            case (r_phase)
                rrle_pkg::PH_CTRL: begin
                    n_left = i_src_byte[6:0] & rrle_pkg::COUNT_MSK;
                    if ((i_src_byte & rrle_pkg::RUN_FLAG) != 8'd0) begin
                        n_phase = rrle_pkg::PH_RUN_LO;
                    end else if (i_src_byte == 8'd0 || full) begin
                        n_phase = rrle_pkg::PH_CTRL;
                    end else begin
                        n_phase = rrle_pkg::PH_LIT_LO;
                    end
                end
                rrle_pkg::PH_RUN_LO, rrle_pkg::PH_LIT_LO: begin
                    if (wide) begin
                        n_low   = i_src_byte;
                        n_phase = (r_phase == rrle_pkg::PH_RUN_LO) ?
                                  rrle_pkg::PH_RUN_HI : rrle_pkg::PH_LIT_HI;
                    end else begin
                        pix  = {8'd0, i_src_byte};
                        have = 1'b1;
                    end
                end
                rrle_pkg::PH_RUN_HI, rrle_pkg::PH_LIT_HI: begin
                    pix  = wide ? {i_src_byte, r_low} : {8'd0, i_src_byte};
                    have = 1'b1;
                end
                default: begin
                    n_phase = rrle_pkg::PH_CTRL;
                end
            endcase
        end

        if (have) begin
            if (wide && pix == rrle_pkg::KEY_PIXEL) begin
                n_alpha = 1'b1;
            end
            // A zero-length run places nothing and does not wrap the row.
            if (!run || r_left != 7'd0) begin
                m = run ? r_left : 7'd1;
                if (room < 11'(m)) begin
                    m = room[6:0];
                end
                if (capleft < 21'(m)) begin
                    m = capleft[6:0];
                end
                col_sum = {1'b0, r_col} + 12'(m);
                n_pw    = r_pw + 21'(m);
                if (col_sum >= {1'b0, w}) begin
                    n_col   = 11'd0;
                    n_row   = r_row + 11'd1;
                    row_end = 1'b1;
                end else begin
                    n_col = col_sum[10:0];
                end
                full_after = (capleft == 21'(m));
            end
            if (run) begin
                n_left  = 7'd0;
                n_phase = rrle_pkg::PH_CTRL;
            end else begin
                n_left  = r_left - 7'd1;
                n_phase = (n_left == 7'd0 || row_end || full_after) ?
                          rrle_pkg::PH_CTRL : rrle_pkg::PH_LIT_LO;
            end
        end
    end

    assign done_after = (w == 11'd0) || (n_row >= rows);

    // Queue entry for this byte.
    always_comb begin
        o_entry.run_v     = have && (m != 7'd0);
        o_entry.run_pix   = pix;
        o_entry.run_n     = m;
        o_entry.pad_v     = i_src_final;
        o_entry.pad_none  = done_after;
        o_entry.wide      = wide;
        o_entry.alpha     = n_alpha;
        o_entry.rows_left = rows - n_row;
        o_entry.w         = w;
        o_entry.col       = n_col;
        o_entry.pw        = n_pw;
        o_entry.cap       = i_cfg.capacity;
        o_push            = accept && (o_entry.run_v || i_src_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rrle_pkg::PH_CTRL;
            r_left  <= 7'd0;
            r_low   <= 8'd0;
            r_col   <= 11'd0;
            r_row   <= 11'd0;
            r_pw    <= 21'd0;
            r_alpha <= 1'b0;
        end else if (accept) begin
            if (i_src_final) begin
                // Last byte of the sprite: start over for the next one.
                r_phase <= rrle_pkg::PH_CTRL;
                r_left  <= 7'd0;
                r_low   <= 8'd0;
                r_col   <= 11'd0;
                r_row   <= 11'd0;
                r_pw    <= 21'd0;
                r_alpha <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_low   <= n_low;
                r_col   <= n_col;
                r_row   <= n_row;
                r_pw    <= n_pw;
                r_alpha <= n_alpha;
            end
        end
    end

endmodule

FILE: hdl/rrle_queue.sv
// ---------------------------------------------------------------------------
// rrle_queue
// Short FIFO of decoded entries between the byte front end and the
// result back end.
// ---------------------------------------------------------------------------
module rrle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rrle_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output rrle_pkg::t_entry    o_entry,
    output rrle_pkg::t_q_status o_status
);

    rrle_pkg::t_entry r_mem [rrle_pkg::Q_DEPTH];
    logic [rrle_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rrle_pkg::Q_PTR_W:0]   r_count, n_count;

    assign o_entry         = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (rrle_pkg::Q_PTR_W + 1)'(rrle_pkg::Q_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/rrle_back.sv
// ---------------------------------------------------------------------------
// rrle_back
// Splits queue entries into result items and finishes the padding run in a
// short pipeline: area product, then clipping and byte count, then the
// output register.
// ---------------------------------------------------------------------------
module rrle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrle_pkg::t_entry    i_entry,
    input  rrle_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic [15:0]         o_pixel_value,
    output logic [20:0]         o_repeat_count,
    output logic                o_is_padding,
    output logic                o_alpha_seen,
    output logic                o_final_item,
    output logic [21:0]         o_bytes_written
);

    logic                 en;
    logic                 r_half;
    logic                 issue_pad;
    logic                 last_piece;
    rrle_pkg::t_piece     piece;
    logic                 r_a_valid, r_b_valid, r_o_valid;
    rrle_pkg::t_piece     r_a;
    rrle_pkg::t_padcalc   r_b, n_b;
    logic [21:0]          prod22;
    logic [21:0]          diff;
    logic [20:0]          padn;
    logic [20:0]          pw_final;
    logic [15:0]          r_o_pix;
    logic [20:0]          r_o_cnt;
    logic                 r_o_pad;
    logic                 r_o_alpha;
    logic [21:0]          r_o_bytes;

    // Whole pipeline advances together whenever the output can move.
    assign en = !r_o_valid || !i_res_stall;

    // Entry with both a run and a pad goes out as two pieces, run first.
    assign issue_pad  = !i_entry.run_v || r_half;
    assign last_piece = !(i_entry.run_v && i_entry.pad_v) || r_half;
    assign o_pop      = en && !i_q_status.empty && last_piece;

    always_comb begin
        piece.is_pad    = issue_pad;
        piece.pix       = issue_pad ? (i_entry.wide ? rrle_pkg::KEY_PIXEL : 16'd0)
                                    : i_entry.run_pix;
        piece.run_n     = i_entry.run_n;
        piece.pad_none  = i_entry.pad_none;
        piece.wide      = i_entry.wide;
        piece.alpha     = i_entry.alpha;
        piece.rows_left = i_entry.rows_left;
        piece.w         = i_entry.w;
        piece.col       = i_entry.col;
        piece.pw        = i_entry.pw;
        piece.cap       = i_entry.cap;
    end

    // Stage A: area left in whole rows and capacity headroom.
    assign prod22 = 22'(r_a.w) * 22'(r_a.rows_left);

    always_comb begin
        n_b.is_pad   = r_a.is_pad;
        n_b.pix      = r_a.pix;
        n_b.run_n    = r_a.run_n;
        n_b.pad_none = r_a.pad_none;
        n_b.wide     = r_a.wide;
        n_b.alpha    = r_a.alpha;
        n_b.prod     = prod22[20:0];
        n_b.capleft  = (r_a.pw < r_a.cap) ? (r_a.cap - r_a.pw) : 21'd0;
        n_b.col      = r_a.col;
        n_b.pw       = r_a.pw;
    end

    // Stage B: remainder of image, clipped to capacity.
    always_comb begin
        diff = {1'b0, r_b.prod} - {11'd0, r_b.col};
        if (r_b.pad_none) begin
            padn = 21'd0;
        end else if (diff[21] || diff[20:0] > r_b.capleft) begin
            // Column beyond a shrunk row width also counts as unbounded.
            padn = r_b.capleft;
        end else begin
            padn = diff[20:0];
        end
        pw_final = r_b.pw + padn;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= piece;
            r_b     <= n_b;
            r_o_pix <= r_b.pix;
            r_o_pad <= r_b.is_pad;
            r_o_alpha <= r_b.is_pad && r_b.alpha;
            if (r_b.is_pad) begin
                r_o_cnt   <= padn;
                r_o_bytes <= r_b.wide ? {pw_final, 1'b0} : {1'b0, pw_final};
            end else begin
                r_o_cnt   <= 21'(r_b.run_n);
                r_o_bytes <= 22'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= !i_q_status.empty;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
            if (!i_q_status.empty) begin
                r_half <= !last_piece;
            end
        end
    end

    assign o_res_valid     = r_o_valid;
    assign o_pixel_value   = r_o_pix;
    assign o_repeat_count  = r_o_cnt;
    assign o_is_padding    = r_o_pad;
    assign o_alpha_seen    = r_o_alpha;
    assign o_final_item    = r_o_pad;
    assign o_bytes_written = r_o_bytes;

endmodule
